// File: rtl/lsdq_pkg.sv
// Shared types and constants for the LWE inner product block.
`timescale 1ns / 1ps
package lsdq_pkg;

    localparam int Q_W        = 15;
    localparam int IDX_W      = 7;
    localparam int ERR_W      = 16;
    localparam int POS_W      = 8;
    localparam int HASH_W     = 56;
    localparam int HASH_SHIFT = 13;
    localparam int HASH_FOLD  = 48;
    localparam int PROD_W     = 2 * Q_W;
    localparam int RED_W      = 32;
    localparam int RED_STEPS  = RED_W / 2;
    localparam int RED_CNT_W  = $clog2(RED_STEPS);

    localparam logic [Q_W-1:0] Q_MIN = Q_W'(2);

    localparam logic MODE_SECRET = 1'b0;
    localparam logic MODE_COLUMN = 1'b1;

    localparam logic REG_MODULUS    = 1'b0;
    localparam logic REG_HASH_START = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_MUL,
        ST_LOAD,
        ST_RED_DOT,
        ST_ACC,
        ST_RED_ERR,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic clr_we;
        logic capture;
        logic sec_write;
        logic mul;
        logic red_load_dot;
        logic red_step;
        logic acc_store;
        logic red_load_err;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic red_done;
        logic item_last;
    } dp_status_t;

endpackage

// File: rtl/lsdq_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module lsdq_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lsdq_ctrl.sv
// Controller state machine that sequences secret writes, element steps and results.
`timescale 1ns / 1ps
module lsdq_ctrl
    import lsdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_mode,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || !result_stall;
    assign accept   = (state_reg == ST_IDLE) && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (status.clr_done) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (item_mode == MODE_SECRET) ? ST_WRITE : ST_READ;
                end
            end
            ST_WRITE:   state_next = ST_IDLE;
            ST_READ:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_RED_DOT;
            ST_RED_DOT: if (status.red_done) state_next = ST_ACC;
            ST_ACC:     state_next = status.item_last ? ST_RED_ERR : ST_IDLE;
            ST_RED_ERR: if (status.red_done) state_next = ST_FINAL;
            ST_FINAL:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        item_stall     = 1'b1;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            ST_CLEAR:   cmd.clr_we = 1'b1;
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            ST_WRITE:   cmd.sec_write = 1'b1;
            ST_READ:    ;
            ST_MUL:     cmd.mul = 1'b1;
            ST_LOAD:    cmd.red_load_dot = 1'b1;
            ST_RED_DOT: cmd.red_step = 1'b1;
            ST_ACC:
            begin
                cmd.acc_store    = 1'b1;
                cmd.red_load_err = status.item_last;
            end
            ST_RED_ERR: cmd.red_step = 1'b1;
            ST_FINAL:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:    ;
        endcase
    end

    assign result_valid = out_valid_reg;

    a_accept_stalls_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_stall)
        else $error("Item stall not raised after an accepted transfer.");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result_valid)
        else $error("Result not presented after output load.");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !cmd.out_load)
        else $error("Output overwritten while a transfer was pending.");

    a_single_datapath_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_we, cmd.capture, cmd.sec_write, cmd.mul,
                  cmd.red_load_dot, cmd.red_step, cmd.acc_store, cmd.out_load}))
        else $error("More than one datapath operation issued in a cycle.");

endmodule

// File: rtl/lsdq_dp.sv
// Datapath with secret store, multiplier, modular reducer, hash and result registers.
`timescale 1ns / 1ps
module lsdq_dp
    import lsdq_pkg::*;
#(
    parameter int SECRET_DEPTH = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status,
    input  logic [Q_W-1:0]          q_eff,
    input  logic [IDX_W-1:0]        hash_start,
    input  logic [IDX_W-1:0]        secret_index,
    input  logic [Q_W-1:0]          element_value,
    input  logic signed [ERR_W-1:0] error_value,
    input  logic                    last_element,
    output logic [Q_W-1:0]          sum_with_error,
    output logic [Q_W-1:0]          error_residue,
    output logic [HASH_W-1:0]       column_hash
);

    localparam int AW = (SECRET_DEPTH > 1) ? $clog2(SECRET_DEPTH) : 1;
    localparam int IW = (AW > POS_W) ? AW : POS_W;

    function automatic logic [Q_W-1:0] red_bit(input logic [Q_W-1:0] r, input logic b,
                                               input logic [Q_W-1:0] q);
        logic [Q_W:0] t;
        t = {r, b};
        if (t >= {1'b0, q})
        begin
            t = t - {1'b0, q};
        end
        return t[Q_W-1:0];
    endfunction

    logic [AW-1:0]        clr_addr_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [Q_W-1:0]       acc_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [Q_W-1:0]       elem_reg;
    logic [ERR_W-1:0]     err_reg;
    logic                 last_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [RED_W-1:0]     red_x_reg;
    logic [Q_W-1:0]       red_rem_reg;
    logic [RED_CNT_W-1:0] red_cnt_reg;
    logic [Q_W-1:0]       sum_reg;
    logic [Q_W-1:0]       eres_reg;
    logic [HASH_W-1:0]    hash_out_reg;

    logic [IW-1:0]        pos_ext;
    logic [IW-1:0]        idx_ext;
    logic                 pos_in_range;
    logic                 idx_in_range;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [Q_W-1:0]       ram_wdata;
    logic [Q_W-1:0]       ram_rdata;
    logic [Q_W-1:0]       s_val;
    logic [63:0]          hash_t;
    logic [63:0]          hash_mix;
    logic [Q_W-1:0]       rem_mid;
    logic [Q_W-1:0]       rem_new;
    logic [ERR_W-1:0]     err_mag;
    logic [Q_W-1:0]       eres;
    logic [Q_W:0]         sum_t;
    logic [Q_W-1:0]       sum_val;

    assign pos_ext      = IW'(pos_reg);
    assign idx_ext      = IW'(idx_reg);
    assign pos_in_range = 32'(pos_reg) < SECRET_DEPTH;
    assign idx_in_range = 32'(idx_reg) < SECRET_DEPTH;

    assign ram_we    = cmd.clr_we || (cmd.sec_write && idx_in_range);
    assign ram_waddr = cmd.clr_we ? clr_addr_reg : idx_ext[AW-1:0];
    assign ram_wdata = cmd.clr_we ? '0 : elem_reg;

    lsdq_ram #(
        .WIDTH (Q_W),
        .DEPTH (SECRET_DEPTH),
        .AW    (AW)
    ) u_secret_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pos_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_val    = pos_in_range ? ram_rdata : '0;
    assign hash_t   = {hash_reg[63-HASH_SHIFT:0], HASH_SHIFT'(0)} + 64'(elem_reg);
    assign hash_mix = hash_t ^ (hash_t >> HASH_FOLD);

    assign rem_mid = red_bit(red_rem_reg, red_x_reg[RED_W-1], q_eff);
    assign rem_new = red_bit(rem_mid, red_x_reg[RED_W-2], q_eff);

    assign err_mag = err_reg[ERR_W-1] ? (~err_reg + ERR_W'(1)) : err_reg;
    assign eres    = (err_reg[ERR_W-1] && (red_rem_reg != '0)) ? (q_eff - red_rem_reg)
                                                                 : red_rem_reg;
    assign sum_t   = {1'b0, acc_reg} + {1'b0, eres};
    assign sum_val = (sum_t >= {1'b0, q_eff}) ? Q_W'(sum_t - {1'b0, q_eff}) : sum_t[Q_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            acc_reg      <= '0;
            hash_reg     <= '0;
            red_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_we)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.mul)
            begin
                if ({1'b0, pos_reg} >= {2'b00, hash_start})
                begin
                    hash_reg <= hash_mix[HASH_W-1:0];
                end
                if (pos_reg != '1)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (cmd.red_load_dot || cmd.red_load_err)
            begin
                red_cnt_reg <= '0;
            end
            else if (cmd.red_step)
            begin
                red_cnt_reg <= red_cnt_reg + RED_CNT_W'(1);
            end
            if (cmd.acc_store)
            begin
                acc_reg <= red_rem_reg;
            end
            if (cmd.out_load)
            begin
                acc_reg  <= '0;
                hash_reg <= '0;
                pos_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= secret_index;
            elem_reg <= element_value;
            err_reg  <= error_value;
            last_reg <= last_element;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(elem_reg) * PROD_W'(s_val);
        end
        if (cmd.red_load_dot)
        begin
            red_x_reg   <= RED_W'(acc_reg) + RED_W'(prod_reg);
            red_rem_reg <= '0;
        end
        else if (cmd.red_load_err)
        begin
            red_x_reg   <= RED_W'(err_mag);
            red_rem_reg <= '0;
        end
        else if (cmd.red_step)
        begin
            red_x_reg   <= {red_x_reg[RED_W-3:0], 2'b00};
            red_rem_reg <= rem_new;
        end
        if (cmd.out_load)
        begin
            sum_reg      <= sum_val;
            eres_reg     <= eres;
            hash_out_reg <= hash_reg;
        end
    end

    assign status.clr_done  = clr_addr_reg == AW'(SECRET_DEPTH - 1);
    assign status.red_done  = red_cnt_reg == RED_CNT_W'(RED_STEPS - 1);
    assign status.item_last = last_reg;

    assign sum_with_error = sum_reg;
    assign error_residue  = eres_reg;
    assign column_hash    = hash_out_reg;

endmodule

// File: rtl/lwe_sample_dot_mod_q_with_hash_top.sv
// Top level of the LWE inner product block with column hash and register port.
//
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      mode, secret_index, element_value,
//                                                   error_value, last_element
// result    out        result_valid / result_stall  sum_with_error, error_residue,
//                                                   column_hash
// config    in         psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// A secret write is stored in the WRITE state; a column element is reduced by the 16-step
// two-bit shift-subtract reducer. For the last element of a column the same reducer
// then also brings the error into range.
// After reset a clearing pass writes zero to every secret entry, with item_stall held
// high. A stalled result does not hold off the next item; only the next result waits
// for the output register to empty.
`timescale 1ns / 1ps
module lwe_sample_dot_mod_q_with_hash_top
    import lsdq_pkg::*;
#(
    parameter int SECRET_DEPTH = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    mode,
    input  logic [IDX_W-1:0]        secret_index,
    input  logic [Q_W-1:0]          element_value,
    input  logic signed [ERR_W-1:0] error_value,
    input  logic                    last_element,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [Q_W-1:0]          sum_with_error,
    output logic [Q_W-1:0]          error_residue,
    output logic [HASH_W-1:0]       column_hash,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [Q_W-1:0]   modulus_reg;
    logic [IDX_W-1:0] hash_start_reg;
    logic [Q_W-1:0]   q_eff;
    logic             cfg_write;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= Q_MIN;
            hash_start_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MODULUS:    modulus_reg    <= pwdata[Q_W-1:0];
                REG_HASH_START: hash_start_reg <= pwdata[IDX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODULUS:    prdata = 32'(modulus_reg);
            REG_HASH_START: prdata = 32'(hash_start_reg);
            default:        prdata = '0;
        endcase
    end

    assign q_eff = (modulus_reg < Q_MIN) ? Q_MIN : modulus_reg;

    lsdq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_mode    (mode),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lsdq_dp #(
        .SECRET_DEPTH (SECRET_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .q_eff          (q_eff),
        .hash_start     (hash_start_reg),
        .secret_index   (secret_index),
        .element_value  (element_value),
        .error_value    (error_value),
        .last_element   (last_element),
        .sum_with_error (sum_with_error),
        .error_residue  (error_residue),
        .column_hash    (column_hash)
    );

endmodule
